>>> rtl/core/frr_pkg.sv
// frr_pkg: beat types, phase and error codes, and a bit-reverse helper for the
// framed response receiver. No dependencies.
package frr_pkg;

  localparam logic [7:0] PREAMBLE_BYTE = 8'h00;
  localparam logic [7:0] START_BYTE    = 8'hFF;
  localparam logic [7:0] DIR_TO_HOST   = 8'hD5;
  localparam logic [7:0] MIN_LENGTH    = 8'd3;
  localparam logic [7:0] HEADER_BYTES  = 8'd2;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_COMMAND = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REVERSE_BITS     = 2'd2;

  typedef enum logic [3:0] {
    ERR_NONE      = 4'd0,
    ERR_START     = 4'd1,
    ERR_LEN_CHECK = 4'd2,
    ERR_TOO_SHORT = 4'd3,
    ERR_DIRECTION = 4'd4,
    ERR_COMMAND   = 4'd5,
    ERR_TOO_LONG  = 4'd6,
    ERR_DATA_SUM  = 4'd7,
    ERR_POSTAMBLE = 4'd8
  } err_e;

  typedef enum logic [9:0] {
    PH_IDLE    = 10'b00_0000_0001,
    PH_START1  = 10'b00_0000_0010,
    PH_START2  = 10'b00_0000_0100,
    PH_LEN     = 10'b00_0000_1000,
    PH_LCS     = 10'b00_0001_0000,
    PH_DIR     = 10'b00_0010_0000,
    PH_CMD     = 10'b00_0100_0000,
    PH_PAYLOAD = 10'b00_1000_0000,
    PH_DCS     = 10'b01_0000_0000,
    PH_POST    = 10'b10_0000_0000
  } phase_e;

  typedef struct packed {
    logic [7:0] wire_byte;
    logic       frame_start;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       payload_valid;
    logic [7:0] payload_index;
    logic       frame_done;
    logic       frame_ok;
    err_e       error_code;
    logic [7:0] payload_length;
  } out_beat_t;

  function automatic logic [7:0] flip8(input logic [7:0] v);
    logic [7:0] r;
    for (int k = 0; k < 8; k++) begin
      r[7-k] = v[k];
    end
    return r;
  endfunction

endpackage

>>> rtl/core/framed_response_receiver.sv
// framed_response_receiver: byte-wide parser for length/checksum framed
// response frames, with an output register and a skid stage.
// Depends on frr_pkg.
//
// Usage: each input beat carries one wire byte and a frame_start flag that
// marks the preamble of a new frame. Every accepted beat yields exactly one
// output beat: a tentative payload byte with its index, or a frame verdict
// (frame_done, frame_ok, error_code, payload_length), or an all-zero beat
// for other bytes. Payload bytes are tentative until frame_done.
// Accepted bytes land in the output register, or in the skid stage while the
// output stalls. Throughput is one byte per cycle while in_stall_o is low, set
// by the single parser stage that updates phase, length, checksum and counter.
// The configuration port writes expected_command, max_payload and
// reverse_bits; write it only while no frame is in flight.
// Reset puts the parser in idle and clears both output stages; registers
// return to expected_command 0, max_payload 255, reverse_bits 1.
// When the receiver stalls, the output beat holds and one more input beat
// lands in the skid stage; after that in_stall_o goes high until the
// stalled output beat is taken.
module framed_response_receiver (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  frr_pkg::in_beat_t           in_beat_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output frr_pkg::out_beat_t          out_beat_o,
  input  logic                        cfg_we_i,
  input  logic [frr_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [7:0]                  cfg_data_i
);
  import frr_pkg::*;

  logic [7:0] exp_cmd_q, max_pay_q;
  logic       rev_q;

  phase_e     phase_q, phase_d;
  logic [7:0] len_q, len_d;
  logic [7:0] sum_q, sum_d;
  logic [7:0] cnt_q, cnt_d;

  logic       out_valid_q, skid_valid_q;
  out_beat_t  out_q, skid_q, res;

  logic       in_acc, out_take;
  logic [7:0] b, sum_add, plen;
  err_e       err;

  assign in_stall_o  = skid_valid_q;
  assign in_acc      = in_valid_i && !skid_valid_q;
  assign out_take    = out_valid_q && !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_cmd_q <= 8'd0;
      max_pay_q <= 8'hFF;
      rev_q     <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_EXPECTED_COMMAND: exp_cmd_q <= cfg_data_i;
        CFG_MAX_PAYLOAD:      max_pay_q <= cfg_data_i;
        CFG_REVERSE_BITS:     rev_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign b       = rev_q ? flip8(in_beat_i.wire_byte) : in_beat_i.wire_byte;
  assign sum_add = sum_q + b;
  assign plen    = len_q - HEADER_BYTES;

  always_comb begin
    phase_d = phase_q;
    len_d   = len_q;
    sum_d   = sum_q;
    cnt_d   = cnt_q;
    err     = ERR_NONE;
    res     = '0;
    if (in_beat_i.frame_start) begin
      phase_d = PH_START1;
      len_d   = 8'd0;
      sum_d   = 8'd0;
      cnt_d   = 8'd0;
      if (b != PREAMBLE_BYTE) err = ERR_START;
    end else begin
      unique case (phase_q)
        PH_IDLE: ;
        PH_START1: begin
          if (b != PREAMBLE_BYTE) err = ERR_START;
          else phase_d = PH_START2;
        end
        PH_START2: begin
          if (b != START_BYTE) err = ERR_START;
          else phase_d = PH_LEN;
        end
        PH_LEN: begin
          len_d   = b;
          phase_d = PH_LCS;
        end
        PH_LCS: begin
          if (8'(len_q + b) != 8'd0) err = ERR_LEN_CHECK;
          else if (len_q < MIN_LENGTH) err = ERR_TOO_SHORT;
          else phase_d = PH_DIR;
        end
        PH_DIR: begin
          sum_d = sum_add;
          if (b != DIR_TO_HOST) err = ERR_DIRECTION;
          else phase_d = PH_CMD;
        end
        PH_CMD: begin
          sum_d = sum_add;
          if (b != 8'(exp_cmd_q + 8'd1)) err = ERR_COMMAND;
          else if (plen > max_pay_q) err = ERR_TOO_LONG;
          else phase_d = PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          sum_d             = sum_add;
          res.payload_valid = 1'b1;
          res.payload_byte  = b;
          res.payload_index = cnt_q;
          cnt_d             = cnt_q + 8'd1;
          if (cnt_d == plen) phase_d = PH_DCS;
        end
        PH_DCS: begin
          sum_d = sum_add;
          if (sum_add != 8'd0) err = ERR_DATA_SUM;
          else phase_d = PH_POST;
        end
        PH_POST: begin
          if (b != PREAMBLE_BYTE) begin
            err = ERR_POSTAMBLE;
          end else begin
            res.frame_done     = 1'b1;
            res.frame_ok       = 1'b1;
            res.payload_length = plen;
            phase_d            = PH_IDLE;
          end
        end
        default: phase_d = PH_IDLE;
      endcase
    end
    if (err != ERR_NONE) begin
      res.frame_done = 1'b1;
      phase_d        = PH_IDLE;
    end
    res.error_code = err;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      len_q   <= 8'd0;
      sum_q   <= 8'd0;
      cnt_q   <= 8'd0;
    end else if (in_acc) begin
      phase_q <= phase_d;
      len_q   <= len_d;
      sum_q   <= sum_d;
      cnt_q   <= cnt_d;
    end
  end

  // output register plus one skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (skid_valid_q) begin
        if (out_take) begin
          out_valid_q  <= 1'b1;
          skid_valid_q <= 1'b0;
        end
      end else if (in_acc) begin
        if (!out_valid_q || out_take) begin
          out_valid_q <= 1'b1;
        end else begin
          skid_valid_q <= 1'b1;
        end
      end else if (out_take) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_take) out_q <= skid_q;
    end else if (in_acc) begin
      if (!out_valid_q || out_take) out_q <= res;
      else skid_q <= res;
    end
  end

endmodule

>>> rtl/core/frr_checker.sv
// frr_checker: port-level assertions for framed_response_receiver, bound to
// the top level below. Depends on frr_pkg.
module frr_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input frr_pkg::out_beat_t            out_beat_o
);
  import frr_pkg::*;

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_beat_o))
    else $error("output beat changed while stalled");

  // a beat accepted into an empty output shows up next cycle
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !out_valid_o |=> out_valid_o)
    else $error("accepted beat did not reach the output");

  // a verdict of success carries no error and closes the frame
  a_ok_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_beat_o.frame_ok |->
      out_beat_o.frame_done && out_beat_o.error_code == ERR_NONE
      && !out_beat_o.payload_valid)
    else $error("frame_ok without a clean frame_done");

  // input only stalls while the output is backed up
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && $past(out_valid_o && out_stall_i))
    else $error("input stalled with the output free");

endmodule

bind framed_response_receiver frr_checker u_frr_checker (.*);

>>> tb/testbench.sv
`timescale 1ns / 100ps
// testbench: self-checking bench for framed_response_receiver, with a byte-level
// frame parser model, random frame builder and random idling on both channels.
// Depends on frr_pkg and the framed_response_receiver rtl.
module testbench;
  import frr_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 4;

  typedef enum int {
    FLAW_NONE, FLAW_PREAMBLE, FLAW_START_CODE, FLAW_LEN_SUM, FLAW_RESIZE,
    FLAW_HEADER, FLAW_TAIL, FLAW_CUT, FLAW_NOISE
  } flaw_e;

  typedef struct packed {
    logic [7:0] raw;
    logic       start;
    logic       fixed;
    out_beat_t  want;
  } dir_row_t;

  localparam out_beat_t QUIET_BEAT  = '0;
  localparam out_beat_t FAIL_START  = '{8'h00, 1'b0, 8'h00, 1'b1, 1'b0, ERR_START, 8'h00};
  localparam out_beat_t FAIL_LEN    = '{8'h00, 1'b0, 8'h00, 1'b1, 1'b0, ERR_LEN_CHECK, 8'h00};
  localparam out_beat_t FAIL_SHORT  = '{8'h00, 1'b0, 8'h00, 1'b1, 1'b0, ERR_TOO_SHORT, 8'h00};
  localparam out_beat_t GOOD_SINGLE = '{8'h00, 1'b0, 8'h00, 1'b1, 1'b1, ERR_NONE, 8'h01};

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_beat_t             in_beat   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_beat_t            out_beat;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_EXPECTED_COMMAND;
  logic [7:0]           cfg_data  = 8'h00;

  // logical bytes; literal results only where the outcome is obvious
  dir_row_t directed_rows [27] = '{
    '{8'h5A, 1'b0, 1'b1, QUIET_BEAT},
    '{8'hFF, 1'b0, 1'b1, QUIET_BEAT},
    '{8'h01, 1'b1, 1'b1, FAIL_START},
    '{8'h00, 1'b1, 1'b0, QUIET_BEAT},
    '{8'h00, 1'b0, 1'b0, QUIET_BEAT},
    '{8'h00, 1'b1, 1'b0, QUIET_BEAT},
    '{8'hFE, 1'b0, 1'b1, FAIL_START},
    '{8'h00, 1'b1, 1'b0, QUIET_BEAT},
    '{8'h00, 1'b0, 1'b0, QUIET_BEAT},
    '{8'hFF, 1'b0, 1'b0, QUIET_BEAT},
    '{8'h03, 1'b0, 1'b0, QUIET_BEAT},
    '{8'hFC, 1'b0, 1'b1, FAIL_LEN},
    '{8'h00, 1'b1, 1'b0, QUIET_BEAT},
    '{8'h00, 1'b0, 1'b0, QUIET_BEAT},
    '{8'hFF, 1'b0, 1'b0, QUIET_BEAT},
    '{8'h02, 1'b0, 1'b0, QUIET_BEAT},
    '{8'hFE, 1'b0, 1'b1, FAIL_SHORT},
    '{8'h00, 1'b1, 1'b0, QUIET_BEAT},
    '{8'h00, 1'b0, 1'b0, QUIET_BEAT},
    '{8'hFF, 1'b0, 1'b0, QUIET_BEAT},
    '{8'h03, 1'b0, 1'b0, QUIET_BEAT},
    '{8'hFD, 1'b0, 1'b0, QUIET_BEAT},
    '{8'hD5, 1'b0, 1'b0, QUIET_BEAT},
    '{8'h01, 1'b0, 1'b0, QUIET_BEAT},
    '{8'hFF, 1'b0, 1'b0, QUIET_BEAT},
    '{8'h2B, 1'b0, 1'b0, QUIET_BEAT},
    '{8'h00, 1'b0, 1'b1, GOOD_SINGLE}
  };

  // parser model state and its copy of the registers
  phase_e     ph     = PH_IDLE;
  logic [7:0] flen   = 8'h00;
  logic [7:0] dsum   = 8'h00;
  logic [7:0] pcount = 8'h00;
  logic [7:0] m_cmd  = 8'h00;
  logic [7:0] m_maxpl = 8'hFF;
  logic       m_rev  = 1'b1;

  out_beat_t pending_beats [$];
  int        mismatches = 0;
  int        beats_sent = 0;
  int        beats_checked = 0;
  int        frames_good = 0;
  int        frames_bad = 0;
  int        idle_cycles = 0;
  int        tx_run = 0;
  bit        tx_gap_on = 1'b0;
  int        rx_left = 0;
  bit        rx_hold = 1'b0;
  bit        quiet_tail = 1'b0;

  framed_response_receiver u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_beat_i   (in_beat),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_beat_o  (out_beat),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // mirror is its own inverse, so this maps both ways
  function automatic logic [7:0] wire_order(input logic [7:0] v);
    return m_rev ? {v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7]} : v;
  endfunction

  function automatic out_beat_t parse_byte(input in_beat_t beat);
    out_beat_t  r;
    logic [7:0] b;
    err_e       e;
    r = '0;
    e = ERR_NONE;
    b = wire_order(beat.wire_byte);
    if (beat.frame_start) begin
      ph = PH_START1;
      flen = 8'h00;
      dsum = 8'h00;
      pcount = 8'h00;
      if (b != PREAMBLE_BYTE) e = ERR_START;
    end else begin
      case (ph)
        PH_START1: begin
          if (b != PREAMBLE_BYTE) e = ERR_START;
          else ph = PH_START2;
        end
        PH_START2: begin
          if (b != START_BYTE) e = ERR_START;
          else ph = PH_LEN;
        end
        PH_LEN: begin
          flen = b;
          ph = PH_LCS;
        end
        PH_LCS: begin
          if (8'(flen + b) != 8'h00) e = ERR_LEN_CHECK;
          else if (flen < MIN_LENGTH) e = ERR_TOO_SHORT;
          else ph = PH_DIR;
        end
        PH_DIR: begin
          dsum = dsum + b;
          if (b != DIR_TO_HOST) e = ERR_DIRECTION;
          else ph = PH_CMD;
        end
        PH_CMD: begin
          dsum = dsum + b;
          if (b != 8'(m_cmd + 8'd1)) e = ERR_COMMAND;
          else if (8'(flen - HEADER_BYTES) > m_maxpl) e = ERR_TOO_LONG;
          else ph = PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          dsum = dsum + b;
          r.payload_valid = 1'b1;
          r.payload_byte = b;
          r.payload_index = pcount;
          pcount = pcount + 8'd1;
          if (pcount == 8'(flen - HEADER_BYTES)) ph = PH_DCS;
        end
        PH_DCS: begin
          dsum = dsum + b;
          if (dsum != 8'h00) e = ERR_DATA_SUM;
          else ph = PH_POST;
        end
        PH_POST: begin
          if (b != PREAMBLE_BYTE) begin
            e = ERR_POSTAMBLE;
          end else begin
            r.frame_done = 1'b1;
            r.frame_ok = 1'b1;
            r.payload_length = 8'(flen - HEADER_BYTES);
            ph = PH_IDLE;
          end
        end
        default: ph = PH_IDLE;
      endcase
    end
    if (e != ERR_NONE) begin
      r.frame_done = 1'b1;
      ph = PH_IDLE;
    end
    r.error_code = e;
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input logic [7:0] got, input logic [7:0] want);
    mismatches++;
    $display("[%0t] mismatch on %s: got %h, wanted %h", $time, what, got, want);
  endtask

  // one beat in; caller is at a rising edge
  task automatic send_beat(input logic [7:0] wb, input logic st, input logic fixed,
                           input out_beat_t want);
    in_beat_t  nb;
    out_beat_t pred;
    int        gap;
    nb.wire_byte = wb;
    nb.frame_start = st;
    gap = 0;
    if (!quiet_tail) begin
      if (tx_run == 0) begin
        tx_run = $urandom_range(1, 20);
        tx_gap_on = ($urandom_range(0, 1) == 0);
      end
      tx_run--;
      if (tx_gap_on && $urandom_range(0, 2) == 0) gap = $urandom_range(1, 14);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_beat <= nb;
    do @(posedge clk); while (in_stall);
    pred = parse_byte(nb);
    if (!fixed) want = pred;
    pending_beats.push_back(want);
    beats_sent++;
    if (want.frame_done) begin
      if (want.frame_ok) frames_good++;
      else frames_bad++;
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_settings(input logic [7:0] cmd, input logic [7:0] maxpl, input logic rev);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= CFG_EXPECTED_COMMAND;
    cfg_data <= cmd;
    @(posedge clk);
    cfg_index <= CFG_MAX_PAYLOAD;
    cfg_data <= maxpl;
    @(posedge clk);
    cfg_index <= CFG_REVERSE_BITS;
    cfg_data <= {7'd0, rev};
    @(posedge clk);
    cfg_we <= 1'b0;
    m_cmd = cmd;
    m_maxpl = maxpl;
    m_rev = rev;
  endtask

  task automatic send_frame(input bit long_frame);
    logic [7:0] body [$];
    logic [7:0] sum, nz;
    flaw_e      flaw;
    int         plen, pos, r;
    nz = 8'($urandom_range(1, 255));
    r = $urandom_range(0, 15);
    flaw = (r <= 7) ? FLAW_NONE : flaw_e'(r - 7);
    if (long_frame) begin
      plen = 253;
      flaw = FLAW_NONE;
    end else if (m_maxpl <= 8'd40 && $urandom_range(0, 3) == 0) begin
      // right at the payload limit or one past it
      plen = int'(m_maxpl) + $urandom_range(0, 1);
      if (plen < 1) plen = 1;
    end else begin
      plen = $urandom_range(1, 12);
    end
    if (flaw == FLAW_NOISE) begin
      repeat ($urandom_range(1, 6))
        send_beat(8'($urandom), $urandom_range(0, 3) == 0, 1'b0, QUIET_BEAT);
      return;
    end
    body.push_back(PREAMBLE_BYTE);
    body.push_back(PREAMBLE_BYTE);
    body.push_back(START_BYTE);
    body.push_back(8'(plen + 2));
    body.push_back(8'(-(plen + 2)));
    body.push_back(DIR_TO_HOST);
    body.push_back(8'(m_cmd + 8'd1));
    sum = 8'(DIR_TO_HOST + m_cmd + 8'd1);
    for (int k = 0; k < plen; k++) begin
      body.push_back(8'($urandom));
      sum = sum + body[body.size() - 1];
    end
    body.push_back(8'(8'h00 - sum));
    body.push_back(PREAMBLE_BYTE);
    case (flaw)
      FLAW_PREAMBLE:   body[0] = body[0] ^ nz;
      FLAW_START_CODE: begin
        pos = $urandom_range(1, 2);
        body[pos] = body[pos] ^ nz;
      end
      FLAW_LEN_SUM:    body[4] = body[4] ^ nz;
      FLAW_RESIZE: begin
        // consistent length check but a length that may be short or wrong
        body[3] = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 2)) : 8'($urandom);
        body[4] = 8'h00 - body[3];
      end
      FLAW_HEADER: begin
        pos = $urandom_range(5, 6);
        body[pos] = body[pos] ^ nz;
      end
      FLAW_TAIL: begin
        pos = $urandom_range(7, body.size() - 1);
        body[pos] = body[pos] ^ nz;
      end
      FLAW_CUT: begin
        // next frame start lands mid-frame
        pos = $urandom_range(1, body.size() - 1);
        while (body.size() > pos) void'(body.pop_back());
      end
      default: ;
    endcase
    foreach (body[k]) send_beat(wire_order(body[k]), k == 0, 1'b0, QUIET_BEAT);
    if ($urandom_range(0, 7) == 0)
      repeat ($urandom_range(1, 4)) send_beat(8'($urandom), 1'b0, 1'b0, QUIET_BEAT);
  endtask

  task automatic run_frames(input int n);
    int first;
    first = beats_sent;
    while (beats_sent - first < n) send_frame(1'b0);
  endtask

  // receiver side: bursts of stall and of free flow
  always @(posedge clk) begin
    if (quiet_tail) begin
      out_stall <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_hold = ($urandom_range(0, 2) == 0);
        rx_left = $urandom_range(1, 14);
      end
      rx_left--;
      out_stall <= rx_hold;
    end
  end

  always @(posedge clk) begin
    out_beat_t head;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_beats.size() == 0) begin
        flag_mismatch("result beat with nothing pending", out_beat.payload_byte, 8'h00);
      end else begin
        head = pending_beats.pop_front();
        beats_checked++;
        if (out_beat.payload_byte !== head.payload_byte)
          flag_mismatch("payload_byte", out_beat.payload_byte, head.payload_byte);
        if (out_beat.payload_valid !== head.payload_valid)
          flag_mismatch("payload_valid", 8'(out_beat.payload_valid),
                        8'(head.payload_valid));
        if (out_beat.payload_index !== head.payload_index)
          flag_mismatch("payload_index", out_beat.payload_index, head.payload_index);
        if (out_beat.frame_done !== head.frame_done)
          flag_mismatch("frame_done", 8'(out_beat.frame_done), 8'(head.frame_done));
        if (out_beat.frame_ok !== head.frame_ok)
          flag_mismatch("frame_ok", 8'(out_beat.frame_ok), 8'(head.frame_ok));
        if (out_beat.error_code !== head.error_code)
          flag_mismatch("error_code", 8'(out_beat.error_code), 8'(head.error_code));
        if (out_beat.payload_length !== head.payload_length)
          flag_mismatch("payload_length", out_beat.payload_length, head.payload_length);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[%0t] watchdog: no beat moved for %0d cycles, %0d results pending",
               $time, idle_cycles, pending_beats.size());
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed_rows[i])
      send_beat(wire_order(directed_rows[i].raw), directed_rows[i].start,
                directed_rows[i].fixed, directed_rows[i].want);
    run_frames(80);
    apply_settings(8'h00, 8'hFF, 1'b0);
    run_frames(40);
    // echo wraps to zero, and every frame is over the payload limit
    apply_settings(8'hFF, 8'h00, 1'b1);
    run_frames(30);
    apply_settings(8'($urandom), 8'($urandom_range(1, 16)), 1'($urandom));
    run_frames(55);
    drain();
    run_frames(55);
    apply_settings(8'hFE, 8'd253, 1'b0);
    send_frame(1'b1);
    run_frames(40);
    apply_settings(8'($urandom), 8'($urandom), 1'($urandom));
    run_frames(40);
    quiet_tail <= 1'b1;
    run_frames(60);
    drain();
    $display("covered %0d input bytes and %0d result beats over six register settings",
             beats_sent, beats_checked);
    $display("%0d frames passed every check, %0d ended on an error, %0d mismatches",
             frames_good, frames_bad, mismatches);
    if (mismatches == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

>>> framed_response_receiver.f
rtl/core/frr_pkg.sv
rtl/core/framed_response_receiver.sv
rtl/core/frr_checker.sv
tb/testbench.sv
